// ----- src/lfa_pkg.sv -----
// shared types and constants for the life automaton stencil block
`default_nettype none

package lfa_pkg;

    // field widths of the stream items, the row register and the neighbor count
    localparam int ROW_W  = 10;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 11;
    localparam int CNT_W  = 4;

    // largest grid height, register reset and B3/S23 rule counts
    localparam logic [CFG_W-1:0] ROWS_MAX   = 11'd1024;
    localparam logic [CFG_W-1:0] ROWS_RESET = 11'd35;
    localparam logic [CNT_W-1:0] BIRTH_CNT  = 4'd3;
    localparam logic [CNT_W-1:0] STAY_CNT   = 4'd2;

    // which neighbor positions of the target cell lie inside the grid
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
        logic left;
        logic right;
    } t_nbr_mask;

endpackage

`default_nettype wire

// ----- src/lfa_cell.sv -----
// one stage of the cell delay line
`default_nettype none

module lfa_cell (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire logic i_d,
    output logic      o_q
);

    logic r_q;

    // take the neighbor's bit on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= 1'b0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- src/lfa_judge.sv -----
// neighbor count and B3/S23 next state of the target cell
`default_nettype none

module lfa_judge (
    input  wire logic              i_self,
    input  wire logic [2:0]        i_top,     // left, middle, right of the row above
    input  wire logic [2:0]        i_bot,     // left, middle, right of the row below
    input  wire logic              i_left,
    input  wire logic              i_right,
    input  wire lfa_pkg::t_nbr_mask i_mask,
    output logic                   o_next
);

    import lfa_pkg::*;

    logic [7:0]       w_nbr;
    logic [CNT_W-1:0] w_cnt;

    // gate each neighbor by its position in the grid
    always_comb begin
        w_nbr[0] = i_top[0] & i_mask.top & i_mask.left;
        w_nbr[1] = i_top[1] & i_mask.top;
        w_nbr[2] = i_top[2] & i_mask.top & i_mask.right;
        w_nbr[3] = i_left   & i_mask.mid & i_mask.left;
        w_nbr[4] = i_right  & i_mask.mid & i_mask.right;
        w_nbr[5] = i_bot[0] & i_mask.bot & i_mask.left;
        w_nbr[6] = i_bot[1] & i_mask.bot;
        w_nbr[7] = i_bot[2] & i_mask.bot & i_mask.right;
    end

    // population count of the eight neighbors
    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < 8; k++) begin
            w_cnt = w_cnt + CNT_W'(w_nbr[k]);
        end
    end

    // birth on three, survival on two or three
    assign o_next = (w_cnt == BIRTH_CNT) || (i_self && (w_cnt == STAY_CNT));

endmodule

`default_nettype wire

// ----- src/life_automaton_stencil.sv -----
// top level: one Life generation over a raster cell stream
//
// The current generation enters in raster order, one cell per clock while
// s_axis_tready is high, COLUMNS cells per row, rows_in_use rows per frame.
// Each cell shifts into a chain of 2*COLUMNS+2 one-bit cells; the result for
// a cell leaves once the cell one row below and one column to the right has
// entered, so the first result of a frame follows the (COLUMNS+2)-th input.
// After the frame's last input the block shifts COLUMNS+1 dead cells through
// the chain to drain the remaining results, holding s_axis_tready low while
// they drain. The chain shifts once per cycle at full rate; output stalls
// stop it. Cells outside the grid count as dead. rows_in_use of 0 acts as 1,
// values above 1024 act as 1024.
`default_nettype none

module life_automaton_stencil #(
    parameter int COLUMNS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // row count register
    input  wire logic                       i_cfg_we,
    input  wire logic [lfa_pkg::CFG_W-1:0]  i_cfg_wdata,
    // input cells
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,   // [0] cell_alive
    // results
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [0] next_alive,
                                                            // [10:1] cell_row,
                                                            // [16:11] cell_col
    output logic                            m_axis_tlast    // frame_last
);

    import lfa_pkg::*;

    localparam int DEPTH  = 2 * COLUMNS + 2;
    localparam int FILL_W = $clog2(COLUMNS + 2);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(COLUMNS + 1);
    localparam logic [FILL_W-1:0] FLUSH_END = FILL_W'(COLUMNS);

    logic [CFG_W-1:0]  r_rows_cfg;
    logic [COL_W-1:0]  r_in_col, r_tgt_col;
    logic [ROW_W-1:0]  r_in_row, r_tgt_row;
    logic [FILL_W-1:0] r_fill, r_flush_cnt;
    logic              r_flush;
    logic              r_out_valid, r_out_next, r_out_last;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic [CFG_W-1:0]  w_rows;
    logic              w_advance, w_shift, w_accept, w_in_last, w_emit, w_frame_last;
    logic              w_next;
    logic              w_win [0:DEPTH];
    logic [CFG_W-1:0]  w_tgt_row_x;
    t_nbr_mask         w_mask;

    // row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= ROWS_RESET;
        end else if (i_cfg_we) begin
            r_rows_cfg <= i_cfg_wdata;
        end
    end

    // clamp the row count into its legal range
    always_comb begin
        if (r_rows_cfg == '0) begin
            w_rows = CFG_W'(1);
        end else if (r_rows_cfg > ROWS_MAX) begin
            w_rows = ROWS_MAX;
        end else begin
            w_rows = r_rows_cfg;
        end
    end

    // handshake and chain shift control
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_advance && !r_flush;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_shift       = w_accept || (w_advance && r_flush);
    assign w_in_last     = (r_in_col == LAST_COL) && ({1'b0, r_in_row} >= (w_rows - CFG_W'(1)));
    assign w_emit        = w_shift && (r_fill == FILL_FULL);
    assign w_frame_last  = r_flush && (r_flush_cnt == FLUSH_END);

    // delay line window: index 0 is the entering cell
    assign w_win[0] = r_flush ? 1'b0 : s_axis_tdata[0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_line
            lfa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_win[g]),
                .o_q     (w_win[g+1])
            );
        end
    endgenerate

    // neighbor positions that fall inside the grid
    always_comb begin
        w_tgt_row_x  = {1'b0, r_tgt_row};
        w_mask.top   = (r_tgt_row != '0) && ((w_tgt_row_x - CFG_W'(1)) < w_rows);
        w_mask.mid   = w_tgt_row_x < w_rows;
        w_mask.bot   = (w_tgt_row_x + CFG_W'(1)) < w_rows;
        w_mask.left  = r_tgt_col != '0;
        w_mask.right = r_tgt_col != LAST_COL;
    end

    lfa_judge u_judge (
        .i_self  (w_win[COLUMNS+1]),
        .i_top   ({w_win[2*COLUMNS], w_win[2*COLUMNS+1], w_win[2*COLUMNS+2]}),
        .i_bot   ({w_win[0], w_win[1], w_win[2]}),
        .i_left  (w_win[COLUMNS+2]),
        .i_right (w_win[COLUMNS]),
        .i_mask  (w_mask),
        .o_next  (w_next)
    );

    // input position counters and frame drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_flush     <= 1'b0;
            r_flush_cnt <= '0;
        end else if (w_accept) begin
            if (w_in_last) begin
                r_in_col    <= '0;
                r_in_row    <= '0;
                r_flush     <= 1'b1;
                r_flush_cnt <= '0;
            end else if (r_in_col == LAST_COL) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + ROW_W'(1);
            end else begin
                r_in_col <= r_in_col + COL_W'(1);
            end
        end else if (w_shift) begin
            if (w_frame_last) begin
                r_flush <= 1'b0;
            end
            r_flush_cnt <= r_flush_cnt + FILL_W'(1);
        end
    end

    // line fill count, cleared after the final drain shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_shift) begin
            if (w_frame_last) begin
                r_fill <= '0;
            end else if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // target position of the next result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_col <= '0;
            r_tgt_row <= '0;
        end else if (w_emit) begin
            if (w_frame_last) begin
                r_tgt_col <= '0;
                r_tgt_row <= '0;
            end else if (r_tgt_col == LAST_COL) begin
                r_tgt_col <= '0;
                r_tgt_row <= r_tgt_row + ROW_W'(1);
            end else begin
                r_tgt_col <= r_tgt_col + COL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_next <= w_next;
            r_out_row  <= r_tgt_row;
            r_out_col  <= r_tgt_col;
            r_out_last <= w_frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_col, r_out_row, r_out_next};
    assign m_axis_tlast  = r_out_last;

    // no input transfer while the frame drains
    a_no_input_in_flush : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !s_axis_tready)
        else $error("input taken during frame drain");

    // fill count never passes a full line
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("line fill count out of range");

    // the frame's final result carries the last column
    a_last_col : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_out_col == LAST_COL))
        else $error("frame end flagged away from the last column");

    // after the final result leaves, the next target is the frame origin
    a_target_wrap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_frame_last) |=> (r_tgt_row == '0 && r_tgt_col == '0 && !r_flush))
        else $error("target position not reset at frame end");

endmodule

`default_nettype wire

// ----- sim/life_automaton_stencil_test.sv -----
// self-checking testbench for the life automaton stencil block
module life_automaton_stencil_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfa_pkg::*;

    localparam int GRID_COLS      = 32;
    localparam int LINE_LEN       = 2 * GRID_COLS + 2;
    localparam int WIN_LEN        = LINE_LEN + 1;
    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 2 * GRID_COLS;
    localparam int STALL_BURST    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // one next-generation result, as carried on the output stream
    typedef struct packed {
        logic             next_alive;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             frame_last;
    } t_life_result;

    // life predictor with its own copy of the delay line, counters and row register
    class t_generation_board;
        bit               cell_line[LINE_LEN];
        bit               window[WIN_LEN];
        bit [COL_W-1:0]   col_cnt;
        bit [ROW_W-1:0]   row_cnt;
        bit [CFG_W-1:0]   rows_reg;
        t_life_result     future_states[$];
        int               errors;

        function new();
            rows_reg = ROWS_RESET;
        endfunction

        // row register as the block applies it
        function int effective_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > ROWS_MAX) return int'(ROWS_MAX);
            return int'(rows_reg);
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        // next state of the cell at tpos; window[k] holds raster position newest-k
        function t_life_result next_state_of(int newest, int tpos, int rows, bit final_cell);
            t_life_result r;
            int d, tr, tc, nr, nc, k, live;
            bit self_alive;
            d = newest - tpos;
            tr = tpos / GRID_COLS;
            tc = tpos % GRID_COLS;
            live = 0;
            self_alive = 1'b0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = tr + dr;
                    nc = tc + dc;
                    k = d - dr * GRID_COLS - dc;
                    // neighbors off the grid or out of the window count as dead
                    if (!(dr == 0 && dc == 0) && nr >= 0 && nc >= 0 && nr < rows &&
                        nc < GRID_COLS && k >= 0 && k < WIN_LEN)
                        live += window[k];
                end
            end
            if (d >= 0 && d < WIN_LEN) self_alive = window[d];
            r.next_alive = (live == int'(BIRTH_CNT)) || (self_alive && live == int'(STAY_CNT));
            r.cell_row   = tr[ROW_W-1:0];
            r.cell_col   = tc[COL_W-1:0];
            r.frame_last = final_cell;
            return r;
        endfunction

        // accepted input cell: queue the results it releases and advance
        function void take_cell(bit alive);
            int rows, here, tpos;
            bit frame_end;
            rows = effective_rows();
            here = int'(row_cnt) * GRID_COLS + int'(col_cnt);
            frame_end = int'(col_cnt) >= GRID_COLS - 1 && int'(row_cnt) >= rows - 1;
            window[0] = alive;
            for (int k = 0; k < LINE_LEN; k++) window[k + 1] = cell_line[k];
            if (frame_end) begin
                // last cell flushes everything still pending in raster order
                for (int j = 0; j <= GRID_COLS + 1; j++) begin
                    tpos = here - GRID_COLS - 1 + j;
                    if (tpos >= 0)
                        future_states.push_back(next_state_of(here, tpos, rows, tpos == here));
                end
            end else if (here - GRID_COLS - 1 >= 0) begin
                future_states.push_back(next_state_of(here, here - GRID_COLS - 1, rows, 1'b0));
            end
            for (int k = LINE_LEN - 1; k > 0; k--) cell_line[k] = cell_line[k - 1];
            cell_line[0] = alive;
            if (frame_end) begin
                col_cnt = 0;
                row_cnt = 0;
            end else if (int'(col_cnt) >= GRID_COLS - 1) begin
                col_cnt = 0;
                row_cnt = row_cnt + 1'b1;
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        task report(string line);
            $display("mismatch: %s", line);
            errors++;
        endtask

        // compare one output transfer with the oldest expected state
        task check_cell(t_life_result got);
            t_life_result want;
            if (future_states.size() == 0) begin
                report($sformatf("result row %0d col %0d with nothing pending",
                                 got.cell_row, got.cell_col));
                return;
            end
            want = future_states.pop_front();
            if (got.next_alive != want.next_alive)
                report($sformatf("next_alive %0d, want %0d at row %0d col %0d",
                                 got.next_alive, want.next_alive, want.cell_row, want.cell_col));
            if (got.cell_row != want.cell_row)
                report($sformatf("cell_row %0d, want %0d", got.cell_row, want.cell_row));
            if (got.cell_col != want.cell_col)
                report($sformatf("cell_col %0d, want %0d", got.cell_col, want.cell_col));
            if (got.frame_last != want.frame_last)
                report($sformatf("frame_last %0d, want %0d at row %0d col %0d",
                                 got.frame_last, want.frame_last, want.cell_row, want.cell_col));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [0] cell_alive
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // [0] next_alive, [10:1] cell_row, [16:11] cell_col
    logic               m_axis_tlast;   // frame_last

    t_generation_board  board = new();
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 stall_burst_req;
    int                 quiet_cycles;

    life_automaton_stencil #(
        .COLUMNS(GRID_COLS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // offer one cell, with random idle cycles ahead of it, until the transfer
    task automatic send_cell(input bit alive);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, alive};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_cell(alive);
    endtask

    task automatic stop_cells();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // wait out every pending result, then let the chain come to rest
    task automatic settle();
        while (board.future_states.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rows(input bit [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.rows_reg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_row(input bit [GRID_COLS-1:0] pattern);
        for (int c = 0; c < GRID_COLS; c++) send_cell(pattern[c]);
    endtask

    // random cells until the frame closes
    task automatic send_frame(input int density);
        do send_cell($urandom_range(99) < density);
        while (!board.at_frame_start());
    endtask

    // change the row count only once the block is idle
    task automatic retune_rows(input bit [CFG_W-1:0] value);
        if (value != board.rows_reg) begin
            stop_cells();
            settle();
            write_rows(value);
        end
    endtask

    // tall register, some rows in, then lowered below the current row
    task automatic cut_frame(input bit [CFG_W-1:0] tall, input int lead, input int density);
        retune_rows(tall);
        repeat (lead) send_cell($urandom_range(99) < density);
        stop_cells();
        settle();
        write_rows(CFG_W'($urandom_range(0, board.row_cnt)));
        send_frame(density);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin : receiver
        int burst_left;
        burst_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_burst_req) begin
                burst_left = STALL_BURST;
                stall_burst_req = 1'b0;
            end
            if (burst_left > 0) begin
                m_axis_tready <= 1'b0;
                burst_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_cell(t_life_result'({m_axis_tdata[0], m_axis_tdata[10:1],
                                             m_axis_tdata[16:11], m_axis_tlast}));
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("life_automaton_stencil_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int density;
        int lead;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        stall_burst_req = 1'b0;
        quiet_cycles    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no idling: full row over a row with both edge columns alive
        write_rows(11'd2);
        send_row(32'hFFFF_FFFF);
        send_row(32'h8007_0001);

        // sender mostly idle: one-row frame, register 0 or 1
        send_idle_pct = 69;
        density = int'($urandom_range(15, 60));
        retune_rows(CFG_W'($urandom_range(0, 1)));
        send_frame(density);

        // receiver mostly stalling, with a long hold-off so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        retune_rows(11'd2);
        stall_burst_req = 1'b1;
        send_frame(int'($urandom_range(30, 70)));

        // both sides idling: tall register lowered in the second row
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        density = int'($urandom_range(15, 60));
        lead = int'($urandom_range(GRID_COLS + 1, 2 * GRID_COLS - 1));
        cut_frame(CFG_W'($urandom_range(1024, 2047)), lead, density);

        stop_cells();
        settle();
        if (board.errors == 0)
            $display("life_automaton_stencil_test: done, clean");
        else
            $display("life_automaton_stencil_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/lfa_pkg.sv
src/lfa_cell.sv
src/lfa_judge.sv
src/life_automaton_stencil.sv
sim/life_automaton_stencil_test.sv
